// File: hdl/kst_pkg.sv
// ============================================================================
// Scancode translator package
// Result types, scancode and modifier constants, and the translation ROMs
// for the set-2 scancode to character translator.
// ============================================================================
`default_nettype none

package kst_pkg;

    // Kind of one result request.
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_LED   = 2'd1,
        KIND_RESET = 2'd2
    } t_kind;

    // One queued result request.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic        last;
    } t_result;

    // Depth of the result queue and its pointer and count widths.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Prefix, modifier and lock scancodes.
    localparam logic [7:0] SC_EXT     = 8'hE0;
    localparam logic [7:0] SC_BREAK   = 8'hF0;
    localparam logic [7:0] SC_LSHIFT  = 8'h12;
    localparam logic [7:0] SC_RSHIFT  = 8'h59;
    localparam logic [7:0] SC_CTRL    = 8'h14;
    localparam logic [7:0] SC_ALT     = 8'h11;
    localparam logic [7:0] SC_CAPS    = 8'h58;
    localparam logic [7:0] SC_NUM     = 8'h77;
    localparam logic [7:0] SC_SCROLL  = 8'h7E;

    // Remapped codes and their targets.
    localparam logic [7:0] SC_F7      = 8'h83;
    localparam logic [7:0] SC_F7_MAP  = 8'h02;
    localparam logic [7:0] SC_F11     = 8'h78;
    localparam logic [7:0] SC_F11_MAP = 8'h08;
    localparam logic [7:0] SC_WIN     = 8'h1F;
    localparam logic [7:0] SC_WIN_MAP = 8'h68;

    // Codes with special handling.
    localparam logic [7:0] SC_Q       = 8'h15;
    localparam logic [7:0] SC_KP_DIV  = 8'h4A;
    localparam logic [7:0] SC_KP_ENT  = 8'h5A;
    localparam logic [7:0] SC_PAD_LO  = 8'h68;
    localparam logic [7:0] SC_HIGH    = 8'h80;

    // Character codes with special handling.
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_DEL     = 8'h89;
    localparam logic [7:0] CH_PAIR_HI = 8'h97;
    localparam logic [7:0] CH_CTRL_LO = 8'h60;
    localparam logic [7:0] CH_CTRL_HI = 8'h7F;
    localparam logic [7:0] CH_CTRL_MSK = 8'h1F;

    // Modifier flag bit positions.
    localparam int MF_LSHIFT = 0;
    localparam int MF_RSHIFT = 1;
    localparam int MF_CAPS   = 2;
    localparam int MF_CTRL   = 3;
    localparam int MF_SCROLL = 4;
    localparam int MF_LALT   = 5;
    localparam int MF_RALT   = 6;
    localparam int MF_NUM    = 7;

    // Main table, codes 0x00 to 0x67.
    localparam logic [7:0] TAB_PLAIN [0:103] = '{
        8'h00, 8'h92, 8'h90, 8'h8E, 8'h8C, 8'h8A, 8'h8B, 8'h95,
        8'h94, 8'h93, 8'h91, 8'h8F, 8'h8D, 8'h09, 8'h5E, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h71, 8'h31, 8'h00,
        8'h00, 8'h00, 8'h79, 8'h73, 8'h61, 8'h77, 8'h32, 8'h00,
        8'h00, 8'h63, 8'h78, 8'h64, 8'h65, 8'h34, 8'h33, 8'h00,
        8'h00, 8'h20, 8'h76, 8'h66, 8'h74, 8'h72, 8'h35, 8'h00,
        8'h00, 8'h6E, 8'h62, 8'h68, 8'h67, 8'h7A, 8'h36, 8'h00,
        8'h00, 8'h00, 8'h6D, 8'h6A, 8'h75, 8'h37, 8'h38, 8'h00,
        8'h00, 8'h2C, 8'h6B, 8'h69, 8'h6F, 8'h30, 8'h39, 8'h00,
        8'h00, 8'h2E, 8'h2D, 8'h6C, 8'h7C, 8'h70, 8'h7E, 8'h00,
        8'h00, 8'h00, 8'h7B, 8'h00, 8'h7D, 8'h60, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h0D, 8'h2B, 8'h00, 8'h23, 8'h00, 8'h00,
        8'h00, 8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00
    };

    // Shifted table, codes 0x00 to 0x67.
    localparam logic [7:0] TAB_SHIFTED [0:103] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0F, 8'h40, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h51, 8'h21, 8'h00,
        8'h00, 8'h00, 8'h59, 8'h53, 8'h41, 8'h57, 8'h22, 8'h00,
        8'h00, 8'h43, 8'h58, 8'h44, 8'h45, 8'h24, 8'h23, 8'h00,
        8'h00, 8'h20, 8'h56, 8'h46, 8'h54, 8'h52, 8'h25, 8'h00,
        8'h00, 8'h4E, 8'h42, 8'h48, 8'h47, 8'h5A, 8'h26, 8'h00,
        8'h00, 8'h00, 8'h4D, 8'h4A, 8'h55, 8'h2F, 8'h28, 8'h00,
        8'h00, 8'h3B, 8'h4B, 8'h49, 8'h4F, 8'h3D, 8'h29, 8'h00,
        8'h00, 8'h3A, 8'h5F, 8'h4C, 8'h5C, 8'h50, 8'h3F, 8'h00,
        8'h00, 8'h00, 8'h5B, 8'h00, 8'h5D, 8'h27, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h0D, 8'h2A, 8'h00, 8'h27, 8'h00, 8'h00,
        8'h00, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h00
    };

    // Keypad tables, indexed by code minus 0x68.
    localparam logic [7:0] TAB_PAD [0:23] = '{
        8'h96, 8'h87, 8'h00, 8'h80, 8'h86, 8'h00, 8'h00, 8'h00,
        8'h88, 8'h89, 8'h83, 8'h00, 8'h81, 8'h82, 8'h1B, 8'h00,
        8'h00, 8'h2B, 8'h85, 8'h2D, 8'h97, 8'h84, 8'h00, 8'h00
    };

    localparam logic [7:0] TAB_PAD_NUM [0:23] = '{
        8'h96, 8'h31, 8'h00, 8'h34, 8'h37, 8'h00, 8'h00, 8'h00,
        8'h30, 8'h2C, 8'h32, 8'h35, 8'h36, 8'h38, 8'h1B, 8'h00,
        8'h00, 8'h2B, 8'h33, 8'h2D, 8'h97, 8'h39, 8'h00, 8'h00
    };

    localparam logic [7:0] TAB_PAD_SCROLL [0:23] = '{
        8'h96, 8'h02, 8'h00, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00,
        8'h88, 8'h89, 8'h83, 8'h00, 8'h81, 8'h82, 8'h1B, 8'h00,
        8'h00, 8'h2B, 8'h85, 8'h2D, 8'h10, 8'h84, 8'h00, 8'h00
    };

    // Two-byte expansions of codes 0x80 to 0x97.
    localparam logic [7:0] PAIR_PLAIN [0:47] = '{
        8'h13, 8'h00, 8'h04, 8'h00, 8'h05, 8'h00, 8'h18, 8'h00,
        8'h12, 8'h00, 8'h03, 8'h00, 8'h11, 8'h53, 8'h11, 8'h44,
        8'h16, 8'h00, 8'h07, 8'h00, 8'h0A, 8'h00, 8'h0B, 8'h41,
        8'h0C, 8'h00, 8'h11, 8'h46, 8'h0B, 8'h42, 8'h0B, 8'h4B,
        8'h0B, 8'h43, 8'h0B, 8'h56, 8'h10, 8'h00, 8'h0B, 8'h58,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h11, 8'h42, 8'h1B, 8'h50
    };

    localparam logic [7:0] PAIR_CTRL [0:47] = '{
        8'h01, 8'h00, 8'h06, 8'h00, 8'h1A, 8'h00, 8'h17, 8'h00,
        8'h11, 8'h45, 8'h11, 8'h58, 8'h11, 8'h52, 8'h11, 8'h43,
        8'h0E, 8'h00, 8'h19, 8'h00, 8'h0A, 8'h00, 8'h0B, 8'h41,
        8'h0C, 8'h00, 8'h11, 8'h41, 8'h0B, 8'h48, 8'h0B, 8'h59,
        8'h11, 8'h54, 8'h11, 8'h56, 8'h1B, 8'h53, 8'h0B, 8'h51,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h11, 8'h42, 8'h1B, 8'h50
    };

endpackage

`default_nettype wire

// File: hdl/keyboard_scancode_translator_top.sv
// ============================================================================
// Keyboard scancode translator
// Translates set-2 scancode bytes into character, LED update and machine
// reset requests, tracking prefixes, modifiers and lock keys.
// ============================================================================
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  ---------------------------------
//   scan     in         i_valid / o_stall    i_scan_code
//   result   out        o_valid / i_stall    o_result_kind, o_out_value,
//                                            o_last_of_run
//
// A scancode is registered when accepted and translated once the queue has
// two free slots, when its zero to two result requests enter a four-entry
// result queue, from which they are offered in order. A new scancode can be
// taken every cycle while the input does not stall; the output port drains
// one request per cycle while i_stall is low. The input stalls while the
// held scancode waits for two free queue slots. The synchronous active-low
// reset clears all prefixes, modifiers and locks and empties the queue.
`default_nettype none

module keyboard_scancode_translator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_scan_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_out_value,
    output logic             o_last_of_run
);
    import kst_pkg::*;

    // Input register.
    logic                r_in_valid;
    logic [7:0]          r_sc;

    // Translator state.
    logic [7:0]          r_mf;
    logic                r_bp;
    logic                r_ep;
    logic [7:0]          n_mf;
    logic                n_bp;
    logic                n_ep;

    // Result queue.
    t_result             r_fifo [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    // Decode outputs.
    logic [1:0]          w_cnt;
    t_result             w_res0;
    t_result             w_res1;
    logic [7:0]          w_scm;
    logic [7:0]          w_pad_off;
    logic [7:0]          w_c;
    logic [7:0]          w_p0;
    logic [7:0]          w_p1;
    logic [5:0]          w_pidx;
    logic                w_ctrl;
    logic                w_alt;
    logic [7:0]          w_led_mf;

    logic                w_proc;
    logic                w_pop;
    logic                w_in_take;

    // Handshake: the held code is translated once two queue slots are free.
    assign w_proc    = r_in_valid && (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_stall   = r_in_valid && !w_proc;
    assign w_in_take = i_valid && !o_stall;
    assign o_valid   = (r_count != '0);
    assign w_pop     = o_valid && !i_stall;

    assign o_result_kind = r_fifo[r_rd_ptr].kind;
    assign o_out_value   = r_fifo[r_rd_ptr].value;
    assign o_last_of_run = r_fifo[r_rd_ptr].last;

    // Translation of the held scancode against the current state.
    always_comb begin
        n_mf      = r_mf;
        n_bp      = r_bp;
        n_ep      = r_ep;
        w_cnt     = 2'd0;
        w_res0    = '{kind: KIND_CHAR, value: 8'h00, last: 1'b1};
        w_res1    = '{kind: KIND_CHAR, value: 8'h00, last: 1'b1};
        w_c       = 8'h00;
        w_p0      = 8'h00;
        w_p1      = 8'h00;
        w_pidx    = 6'd0;
        w_led_mf  = r_mf;
        w_ctrl    = r_mf[MF_CTRL];
        w_alt     = r_mf[MF_LALT] || r_mf[MF_RALT];

        // Remapped codes.
        if (r_sc == SC_F7) begin
            w_scm = SC_F7_MAP;
        end else if (r_sc == SC_F11) begin
            w_scm = SC_F11_MAP;
        end else if (r_sc == SC_WIN) begin
            w_scm = SC_WIN_MAP;
        end else begin
            w_scm = r_sc;
        end
        w_pad_off = w_scm - SC_PAD_LO;

        case (r_sc)
            SC_EXT: begin
                n_ep = 1'b1;
            end
            SC_BREAK: begin
                n_bp = 1'b1;
            end
            SC_LSHIFT, SC_RSHIFT, SC_CTRL, SC_ALT: begin
                if (r_sc == SC_LSHIFT && r_ep) begin
                    // Fake shift: only drops the prefixes.
                    n_bp = 1'b0;
                    n_ep = 1'b0;
                end else begin
                    logic [2:0] bit_sel;
                    bit_sel = 3'(MF_LSHIFT);
                    if (r_sc == SC_RSHIFT) bit_sel = 3'(MF_RSHIFT);
                    if (r_sc == SC_CTRL)   bit_sel = 3'(MF_CTRL);
                    if (r_sc == SC_ALT)    bit_sel = r_ep ? 3'(MF_RALT) : 3'(MF_LALT);
                    n_mf[bit_sel] = !r_bp;
                    n_bp = 1'b0;
                    n_ep = 1'b0;
                end
            end
            SC_CAPS, SC_NUM, SC_SCROLL: begin
                // Lock keys toggle on press and report the LEDs either way.
                if (r_bp) begin
                    n_bp = 1'b0;
                end else if (r_sc == SC_CAPS) begin
                    n_mf[MF_CAPS] = !r_mf[MF_CAPS];
                end else if (r_sc == SC_NUM) begin
                    n_mf[MF_NUM] = !r_mf[MF_NUM];
                end else begin
                    n_mf[MF_SCROLL] = !r_mf[MF_SCROLL];
                end
                w_led_mf = n_mf;
                w_cnt    = 2'd1;
                w_res0   = '{kind: KIND_LED,
                             value: {5'd0, w_led_mf[MF_SCROLL], w_led_mf[MF_CAPS],
                                     w_led_mf[MF_NUM]},
                             last: 1'b1};
            end
            default: begin
                // Table lookup.
                if (r_bp) begin
                    n_bp = 1'b0;
                    n_ep = 1'b0;
                end else if (r_ep) begin
                    n_ep = 1'b0;
                    if (w_scm == SC_KP_DIV) begin
                        w_c = CH_SLASH;
                    end else if (w_scm == SC_KP_ENT) begin
                        w_c = TAB_PLAIN[w_scm[6:0]];
                    end else if (w_scm >= SC_PAD_LO && w_scm < SC_HIGH) begin
                        w_c = r_mf[MF_SCROLL] ? TAB_PAD_SCROLL[w_pad_off[4:0]]
                                              : TAB_PAD[w_pad_off[4:0]];
                    end
                end else if (w_scm == SC_Q && r_mf[MF_RALT]) begin
                    w_c = CH_AT;
                end else if (w_scm < SC_PAD_LO) begin
                    if (r_mf[MF_CTRL]) begin
                        w_c = TAB_PLAIN[w_scm[6:0]];
                        if (w_c >= CH_CTRL_LO && w_c <= CH_CTRL_HI) begin
                            w_c = w_c & CH_CTRL_MSK;
                        end else if (w_c < SC_HIGH) begin
                            w_c = 8'h00;
                        end
                    end else if (r_mf[MF_LSHIFT] || r_mf[MF_RSHIFT] || r_mf[MF_CAPS]) begin
                        w_c = TAB_SHIFTED[w_scm[6:0]];
                    end else begin
                        w_c = TAB_PLAIN[w_scm[6:0]];
                    end
                end else if (w_scm < SC_HIGH) begin
                    w_c = r_mf[MF_NUM] ? TAB_PAD_NUM[w_pad_off[4:0]]
                                       : TAB_PAD[w_pad_off[4:0]];
                end

                // Expansion of the looked-up code into requests.
                w_pidx = {w_c[4:0], 1'b0};
                if (w_c != 8'h00) begin
                    if (w_c >= SC_HIGH || (w_ctrl && w_c == CH_ESC)) begin
                        if ((w_ctrl && w_alt && w_c == CH_DEL) ||
                            (w_ctrl && w_c == CH_ESC)) begin
                            w_cnt  = 2'd1;
                            w_res0 = '{kind: KIND_RESET, value: 8'h00, last: 1'b1};
                        end else if (w_c <= CH_PAIR_HI) begin
                            w_p0 = w_ctrl ? PAIR_CTRL[w_pidx] : PAIR_PLAIN[w_pidx];
                            w_p1 = w_ctrl ? PAIR_CTRL[w_pidx + 6'd1]
                                          : PAIR_PLAIN[w_pidx + 6'd1];
                            if (w_p0 != 8'h00) begin
                                w_res0 = '{kind: KIND_CHAR, value: w_p0,
                                           last: (w_p1 == 8'h00)};
                                w_res1 = '{kind: KIND_CHAR, value: w_p1, last: 1'b1};
                                w_cnt  = (w_p1 != 8'h00) ? 2'd2 : 2'd1;
                            end
                        end
                    end else begin
                        w_cnt  = 2'd1;
                        w_res0 = '{kind: KIND_CHAR, value: w_c, last: 1'b1};
                    end
                end
            end
        endcase
    end

    // Control registers: input stage, translator state and queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mf       <= 8'h00;
            r_bp       <= 1'b0;
            r_ep       <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            if (w_proc) begin
                r_mf     <= n_mf;
                r_bp     <= n_bp;
                r_ep     <= n_ep;
                r_wr_ptr <= r_wr_ptr + PTR_W'(w_cnt);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (w_proc ? CNT_W'(w_cnt) : CNT_W'(0))
                               - (w_pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Payload registers: scancode capture and queue writes.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_sc <= i_scan_code;
        end
        if (w_proc && w_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res0;
        end
        if (w_proc && w_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= w_res1;
        end
    end

endmodule

`default_nettype wire
